// ===== rtl/core/crcp_pkg.sv =====
// Shared types and constants for the CRC codeword packer.
// Used by the top level, front end and packer; depends on nothing else.
`default_nettype none

package crcp_pkg;

  // Fixed field widths.
  localparam int BYTE_W     = 8;
  localparam int NIBBLE_W   = 4;
  localparam int GEN_POLY_W = 17;
  localparam int GEN_LEN_W  = 5;
  localparam int PAD_W      = 3;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_GEN_POLY   = 2'd0;
  localparam logic [1:0] REG_GEN_LEN    = 2'd1;
  localparam logic [1:0] REG_WORD_MODE  = 2'd2;
  localparam logic [1:0] REG_BYTE_COUNT = 2'd3;

  // Register reset values.
  localparam logic [GEN_POLY_W-1:0] GEN_POLY_RST  = 17'd13;
  localparam logic [GEN_LEN_W-1:0]  GEN_LEN_RST   = 5'd4;
  localparam logic                  WORD_MODE_RST = 1'b1;

  // Queue depths.
  localparam int JOB_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Control part of one job handed from the front end to the packer.
  typedef struct packed {
    logic             hdr;   // emit the pad count byte before the bits
    logic [PAD_W-1:0] pad;   // number of zero pad bits
    logic             last;  // this word closes the stream
  } job_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/crc_codeword_packer.sv =====
// CRC codeword packer top level: registers, front end, job queue, bit packer
// and result queue. Depends on crcp_pkg, crcp_front, crcp_fifo and crcp_back.
// A word goes through the front end into the job queue. The packer pushes the
// pad byte as it loads the first job; other bytes follow after the job is loaded.
// Throughput: one result byte per cycle while the result queue has room.
// Reset: rst (synchronous) clears queues, counters and packer, loads defaults.
`default_nettype none

module crc_codeword_packer #(
  parameter int MAX_GEN_LEN = 17,
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input queue side.
  input  wire logic                                push,
  input  wire logic [crcp_pkg::BYTE_W-1:0]         data_byte,
  output logic                                     full,
  // Result queue side.
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [crcp_pkg::BYTE_W-1:0]              out_byte,
  output logic                                     last,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [crcp_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [crcp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [crcp_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  import crcp_pkg::*;

  localparam int BITS_W = 2 * MAX_GEN_LEN + 6;
  localparam int NW     = $clog2(BITS_W + 8);
  localparam int CTL_W  = $bits(job_ctl_t);
  localparam int JOB_W  = CTL_W + NW + BITS_W;
  localparam int OUT_W  = BYTE_W + 1;

  // Configuration registers.
  logic [GEN_POLY_W-1:0]  gen_poly;
  logic [GEN_LEN_W-1:0]   gen_len;
  logic                   word_mode;
  logic [COUNT_WIDTH-1:0] byte_count;
  logic                   cfg_write;
  logic [1:0]             reg_idx;

  // Front end to job queue.
  job_ctl_t               front_ctl;
  logic [NW-1:0]          front_len;
  logic [BITS_W-1:0]      front_bits;
  logic                   mid_push;
  logic                   mid_full;

  // Job queue to packer.
  logic [JOB_W-1:0]       mid_rdata;
  logic                   mid_empty;
  logic                   mid_pop;
  job_ctl_t               back_ctl;
  logic [NW-1:0]          back_len;
  logic [BITS_W-1:0]      back_bits;

  // Packer to result queue.
  logic                   out_push;
  logic [OUT_W-1:0]       out_wdata;
  logic                   out_full;
  logic [OUT_W-1:0]       out_rdata;

  // The register port never waits. A write lands in the access phase; the
  // register index is the word address, so the low two address bits are
  // ignored.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_poly   <= GEN_POLY_RST;
      gen_len    <= GEN_LEN_RST;
      word_mode  <= WORD_MODE_RST;
      byte_count <= COUNT_WIDTH'(1);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_GEN_POLY:   gen_poly   <= pwdata[GEN_POLY_W-1:0];
        REG_GEN_LEN:    gen_len    <= pwdata[GEN_LEN_W-1:0];
        REG_WORD_MODE:  word_mode  <= pwdata[0];
        REG_BYTE_COUNT: byte_count <= pwdata[COUNT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GEN_POLY:   prdata = APB_DATA_W'(gen_poly);
      REG_GEN_LEN:    prdata = APB_DATA_W'(gen_len);
      REG_WORD_MODE:  prdata = APB_DATA_W'(word_mode);
      REG_BYTE_COUNT: prdata = APB_DATA_W'(byte_count);
      default:        prdata = '0;
    endcase
  end

  // The front end accepts a word whenever the job queue has room. It drops
  // words outside the configured stream and turns every other word into a
  // job: its codeword bits, right-aligned, with the pad bits counted in the
  // length of the first job.
  crcp_front #(
    .MAX_GEN_LEN (MAX_GEN_LEN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data_byte  (data_byte),
    .full       (full),
    .gen_poly   (gen_poly),
    .gen_len    (gen_len),
    .word_mode  (word_mode),
    .byte_count (byte_count),
    .job_push   (mid_push),
    .job_ctl    (front_ctl),
    .job_len    (front_len),
    .job_bits   (front_bits),
    .job_full   (mid_full)
  );

  // The job queue lets the front end keep taking words while the packer is
  // still draining a long codeword or the result side is stalled.
  crcp_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata ({front_ctl, front_len, front_bits}),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign back_ctl  = mid_rdata[JOB_W-1 -: CTL_W];
  assign back_len  = mid_rdata[BITS_W +: NW];
  assign back_bits = mid_rdata[BITS_W-1:0];

  // The packer holds fewer than eight leftover bits between words. It
  // appends the next job as soon as the leftover drops below one byte, in
  // the same cycle as the byte that gets it there.
  crcp_back #(
    .MAX_GEN_LEN (MAX_GEN_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!mid_empty),
    .job_ctl   (back_ctl),
    .job_len   (back_len),
    .job_bits  (back_bits),
    .job_pop   (mid_pop),
    .out_push  (out_push),
    .out_data  (out_wdata),
    .out_full  (out_full)
  );

  // Result queue: a finished byte waits here while the packer goes on.
  crcp_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign last     = out_rdata[BYTE_W];
  assign out_byte = out_rdata[BYTE_W-1:0];

  // The packer must never push into a full result queue, or a result byte is lost.
  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("packer pushed into a full result queue");

  // The front end only forwards a word when the job queue has room.
  a_job_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> !mid_full)
    else $error("front end pushed into a full job queue");

  // Only one job of the stream may ask for the pad count byte.
  a_single_header: assert property (@(posedge clk) disable iff (rst)
    (mid_push && front_ctl.hdr) |=> !(mid_push && front_ctl.hdr))
    else $error("second header job after the first word");

endmodule

`default_nettype wire

// ===== rtl/core/crcp_fifo.sv =====
// Small show-ahead queue built from registers.
// Used for the job queue and the result queue; needs no package.
`default_nettype none

module crcp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crcp_front.sv =====
// Front end: takes input words, divides the datawords by the generator and
// builds one right-aligned codeword job per word in the stream. Depends on crcp_pkg.
`default_nettype none

module crcp_front #(
  parameter int MAX_GEN_LEN  = 17,
  parameter int COUNT_WIDTH  = 24,
  localparam int BITS_W      = 2 * MAX_GEN_LEN + 6,
  localparam int NW          = $clog2(BITS_W + 8)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  input  wire logic [crcp_pkg::BYTE_W-1:0]        data_byte,
  output logic                                    full,
  input  wire logic [crcp_pkg::GEN_POLY_W-1:0]    gen_poly,
  input  wire logic [crcp_pkg::GEN_LEN_W-1:0]     gen_len,
  input  wire logic                               word_mode,
  input  wire logic [COUNT_WIDTH-1:0]             byte_count,
  output logic                                    job_push,
  output crcp_pkg::job_ctl_t                      job_ctl,
  output logic [NW-1:0]                           job_len,
  output logic [BITS_W-1:0]                       job_bits,
  input  wire logic                               job_full
);

  import crcp_pkg::*;

  localparam int GLW   = $clog2(MAX_GEN_LEN + 1);
  localparam int REM_W = MAX_GEN_LEN - 1;
  localparam int PW    = MAX_GEN_LEN + GEN_POLY_W;

  logic [COUNT_WIDTH-1:0] bytes_seen;
  logic                   header_sent;

  logic [GLW-1:0]         g;
  logic [GLW:0]           r;
  logic [GLW-1:0]         lshift;
  logic [PW-1:0]          gen_shift;
  logic [REM_W-1:0]       gen_left;
  logic [REM_W-1:0]       rem8;
  logic [REM_W-1:0]       rem_hi;
  logic [REM_W-1:0]       rem_lo;
  logic [BITS_W-1:0]      cw_hi;
  logic [BITS_W-1:0]      cw_lo;
  logic [BITS_W-1:0]      cw8;
  logic [NW-1:0]          base_len;
  logic [PAD_W-1:0]       per3;
  logic [PAD_W-1:0]       total3;
  logic [PAD_W-1:0]       pad;
  logic                   ignore;
  logic                   accept;
  logic [COUNT_WIDTH-1:0] seen_next;

  // Serial CRC over the low four or all eight bits of d, MSB first, with the
  // generator's low bits held left-aligned. The generator's top bit only
  // touches the bit that leaves the window, so it never matters.
  function automatic logic [REM_W-1:0] crc_div(input logic [BYTE_W-1:0] d,
                                               input logic            eight,
                                               input logic [REM_W-1:0] gl);
    logic [REM_W-1:0] rr;
    logic             fb;
    rr = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (eight || (i < NIBBLE_W)) begin
        fb = d[i] ^ rr[REM_W-1];
        rr = (rr << 1) ^ (fb ? gl : '0);
      end
    end
    return rr;
  endfunction

  // Effective generator length: zero counts as one, large values saturate.
  always_comb begin
    if (gen_len == '0) begin
      g = GLW'(1);
    end else if (int'(gen_len) > MAX_GEN_LEN) begin
      g = GLW'(MAX_GEN_LEN);
    end else begin
      g = GLW'(gen_len);
    end
  end

  assign r         = (GLW + 1)'(g) - (GLW + 1)'(1);
  assign lshift    = GLW'(MAX_GEN_LEN) - g;
  assign gen_shift = PW'(gen_poly) << lshift;
  assign gen_left  = gen_shift[REM_W-1:0];

  assign rem8   = crc_div(data_byte, 1'b1, gen_left) >> lshift;
  assign rem_hi = crc_div(BYTE_W'(data_byte[BYTE_W-1:NIBBLE_W]), 1'b0, gen_left) >> lshift;
  assign rem_lo = crc_div(BYTE_W'(data_byte[NIBBLE_W-1:0]), 1'b0, gen_left) >> lshift;

  assign cw8   = (BITS_W'(data_byte) << r) | BITS_W'(rem8);
  assign cw_hi = (BITS_W'(data_byte[BYTE_W-1:NIBBLE_W]) << r) | BITS_W'(rem_hi);
  assign cw_lo = (BITS_W'(data_byte[NIBBLE_W-1:0]) << r) | BITS_W'(rem_lo);

  // Pad so that byte_count words fill whole output bytes.
  assign per3   = word_mode ? PAD_W'(r) : PAD_W'(r << 1);
  assign total3 = PAD_W'(byte_count[PAD_W-1:0] * per3);
  assign pad    = PAD_W'(0) - total3;

  assign base_len = word_mode ? (NW'(BYTE_W) + NW'(r))
                              : (NW'(BYTE_W) + NW'(r) + NW'(r));

  assign ignore    = (byte_count == '0) || (bytes_seen >= byte_count);
  assign full      = job_full;
  assign accept    = push && !full;
  assign seen_next = bytes_seen + COUNT_WIDTH'(1);
  assign job_push  = accept && !ignore;

  always_comb begin
    job_ctl.hdr  = !header_sent;
    job_ctl.pad  = pad;
    job_ctl.last = (seen_next == byte_count);
    job_len      = base_len + (header_sent ? NW'(0) : NW'(pad));
    if (word_mode) begin
      job_bits = cw8;
    end else begin
      job_bits = (cw_hi << (r + (GLW + 1)'(NIBBLE_W))) | cw_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen  <= '0;
      header_sent <= 1'b0;
    end else if (job_push) begin
      bytes_seen  <= seen_next;
      header_sent <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crcp_back.sv =====
// Back end: packs job bits MSB first into bytes, one byte per cycle while the
// output has room, and emits the pad count byte ahead of the first job. Depends on crcp_pkg.
`default_nettype none

module crcp_back #(
  parameter int MAX_GEN_LEN  = 17,
  localparam int BITS_W      = 2 * MAX_GEN_LEN + 6,
  localparam int NW          = $clog2(BITS_W + 8)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          job_valid,
  input  wire crcp_pkg::job_ctl_t            job_ctl,
  input  wire logic [NW-1:0]                 job_len,
  input  wire logic [BITS_W-1:0]             job_bits,
  output logic                               job_pop,
  output logic                               out_push,
  output logic [crcp_pkg::BYTE_W:0]          out_data,
  input  wire logic                          out_full
);

  import crcp_pkg::*;

  localparam int ACC_W = BITS_W + 14;
  localparam int CNTW  = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]  bits;
  logic [CNTW-1:0]   cnt;
  logic              job_last;

  logic              emit;
  logic [CNTW-1:0]   cnt_after;
  logic              load;
  logic [ACC_W-1:0]  shifted;
  logic [BYTE_W-2:0] rest;
  logic [ACC_W-1:0]  merged;

  assign emit      = (cnt >= CNTW'(BYTE_W)) && !out_full;
  assign cnt_after = emit ? (cnt - CNTW'(BYTE_W)) : cnt;
  // A header job pushes its byte in the load cycle, so it needs the output
  // slot to itself.
  assign load      = job_valid && (cnt_after < CNTW'(BYTE_W)) &&
                     (!job_ctl.hdr || (!out_full && !emit));
  assign job_pop   = load;

  assign shifted = bits >> (cnt - CNTW'(BYTE_W));
  assign rest    = bits[BYTE_W-2:0] & ((BYTE_W - 1)'((BYTE_W)'(1) << cnt_after)
                                       - (BYTE_W - 1)'(1));
  assign merged  = (ACC_W'(rest) << job_len) | ACC_W'(job_bits);

  // Every job carries at least eight bits, so the header byte is never the
  // final byte of a word.
  always_comb begin
    out_push = emit || (load && job_ctl.hdr);
    if (emit) begin
      out_data = {job_last && (cnt_after < CNTW'(BYTE_W)), shifted[BYTE_W-1:0]};
    end else begin
      out_data = {1'b0, BYTE_W'(job_ctl.pad)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      job_last <= 1'b0;
    end else if (load) begin
      cnt      <= cnt_after + CNTW'(job_len);
      job_last <= job_ctl.last;
    end else if (emit) begin
      cnt      <= cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bits <= merged;
    end
  end

endmodule

`default_nettype wire
